>>> hw/rtl/oba_pkg.sv
// oba_pkg: shared constants, types and helpers for the owned block allocator.
// Used by oba_tag_ram and owned_block_allocator; no dependencies.
package oba_pkg;

	localparam int NUM_BLOCKS = 32;
	localparam int OWNER_BITS = 8;
	localparam int IDX_W      = $clog2(NUM_BLOCKS);
	localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
	localparam int CMD_W      = 2;
	localparam int OWNER_ID_W = 8;
	localparam int BLK_IDX_W  = 6;
	localparam int GRANT_W    = 5;

	typedef logic [CMD_W-1:0]      cmd_t;
	typedef logic [IDX_W-1:0]      blk_idx_t;
	typedef logic [OWNER_BITS-1:0] tag_t;

	localparam cmd_t CMD_ALLOC       = 2'd0;
	localparam cmd_t CMD_FREE        = 2'd1;
	localparam cmd_t CMD_RELEASE_ALL = 2'd2;

	typedef struct packed {
		logic     we;
		blk_idx_t waddr;
		tag_t     wdata;
		logic     re;
		blk_idx_t raddr;
	} tag_req_t;

	// lowest clear bit; MSB of result flags that one was found
	function automatic logic [IDX_W:0] pick_free(logic [NUM_BLOCKS-1:0] used);
		logic [IDX_W:0] res;
		res = '0;
		for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
			if (!used[i]) begin
				res = {1'b1, IDX_W'(i)};
			end
		end
		return res;
	endfunction

endpackage

>>> hw/rtl/oba_tag_ram.sv
// oba_tag_ram: owner tag store, one write and one registered read port.
// Depends on oba_pkg.
module oba_tag_ram (
	input  logic             clk,
	input  oba_pkg::tag_req_t req,
	output oba_pkg::tag_t    rd_data
);
	import oba_pkg::*;

	tag_t mem [NUM_BLOCKS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data <= mem[req.raddr];
		end
	end

endmodule

>>> hw/rtl/owned_block_allocator.sv
// owned_block_allocator: first-fit block allocator with per-block owner tags.
// Depends on oba_pkg and oba_tag_ram.
//
//  channel  dir  tdata / tuser                               word
//  s_*      in   tuser[1:0] cmd; tdata[7:0] owner_id,        one command
//                tdata[13:8] block_index
//  m_*      out  tdata[0] status, tdata[5:1] granted_index   one result
//
// Allocate: pick from in-use flops, tag write, result.
// Free: tag RAM read, compare, result.
// Release-all: a sweep of the tag RAM read port.
// A stalled m_tready holds up the result step only.
// Reset clears the in-use flops at once; tags of idle blocks are never used.
module owned_block_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // owner_id[7:0], block_index[13:8], zero pad
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // status[0], granted_index[5:1], zero pad
);
	import oba_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_FREE, ST_REL, ST_DONE} state_t;

	state_t                 state_q;
	logic [NUM_BLOCKS-1:0]  in_use_q;
	tag_t                   owner_q;
	blk_idx_t               idx_q;
	logic                   idx_ok_q;
	logic [CNT_W-1:0]       cnt_q;
	blk_idx_t               rel_addr_s1;
	logic                   rel_vld_s1;
	logic                   res_status_q;
	logic [GRANT_W-1:0]     res_grant_q;
	logic                   m_tvalid_q;
	logic                   m_status_q;
	logic [GRANT_W-1:0]     m_grant_q;

	cmd_t                   in_cmd;
	tag_t                   in_owner;
	logic [BLK_IDX_W-1:0]   in_idx;
	logic                   accept;
	logic [IDX_W:0]         pick;
	logic                   any_free;
	blk_idx_t               pick_idx;
	tag_t                   tag_rd;
	tag_req_t               tag_req;
	logic                   free_ok;
	logic                   rel_hit;
	logic                   sweep_more;

	assign in_cmd   = s_tuser;
	assign in_owner = tag_t'(s_tdata[OWNER_ID_W-1:0]);
	assign in_idx   = s_tdata[OWNER_ID_W +: BLK_IDX_W];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign pick     = pick_free(in_use_q);
	assign any_free = pick[IDX_W];
	assign pick_idx = pick[IDX_W-1:0];

	assign free_ok    = idx_ok_q && in_use_q[idx_q] && (tag_rd == owner_q);
	assign rel_hit    = rel_vld_s1 && (tag_rd == owner_q);
	assign sweep_more = (cnt_q < CNT_W'(NUM_BLOCKS));

	always_comb begin
		tag_req = '0;
		if (accept) begin
			unique case (in_cmd)
				CMD_ALLOC: begin
					tag_req.we    = any_free;
					tag_req.waddr = pick_idx;
					tag_req.wdata = in_owner;
				end
				CMD_FREE: begin
					tag_req.re    = 1'b1;
					tag_req.raddr = IDX_W'(in_idx);
				end
				CMD_RELEASE_ALL: begin
					tag_req.re    = 1'b1;
					tag_req.raddr = '0;
				end
				default: ;
			endcase
		end else if (state_q == ST_REL && sweep_more) begin
			tag_req.re    = 1'b1;
			tag_req.raddr = cnt_q[IDX_W-1:0];
		end
	end

	oba_tag_ram u_tag_ram (
		.clk     (clk),
		.req     (tag_req),
		.rd_data (tag_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			in_use_q     <= '0;
			owner_q      <= '0;
			idx_q        <= '0;
			idx_ok_q     <= 1'b0;
			cnt_q        <= '0;
			rel_addr_s1  <= '0;
			rel_vld_s1   <= 1'b0;
			res_status_q <= 1'b0;
			res_grant_q  <= '0;
			m_tvalid_q   <= 1'b0;
			m_status_q   <= 1'b0;
			m_grant_q    <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						owner_q  <= in_owner;
						idx_q    <= IDX_W'(in_idx);
						idx_ok_q <= (32'(in_idx) < NUM_BLOCKS);
						unique case (in_cmd)
							CMD_ALLOC: begin
								if (any_free) begin
									in_use_q[pick_idx] <= 1'b1;
								end
								res_status_q <= !any_free;
								res_grant_q  <= any_free ? GRANT_W'(pick_idx) : '0;
								state_q      <= ST_DONE;
							end
							CMD_FREE: begin
								res_status_q <= 1'b1;
								res_grant_q  <= '0;
								state_q      <= ST_FREE;
							end
							CMD_RELEASE_ALL: begin
								res_status_q <= 1'b1;
								res_grant_q  <= '0;
								cnt_q        <= CNT_W'(1);
								rel_addr_s1  <= '0;
								rel_vld_s1   <= 1'b1;
								state_q      <= ST_REL;
							end
							default: begin
								res_status_q <= 1'b1;
								res_grant_q  <= '0;
								state_q      <= ST_DONE;
							end
						endcase
					end
				end
				ST_FREE: begin
					if (free_ok) begin
						in_use_q[idx_q] <= 1'b0;
						res_status_q    <= 1'b0;
					end
					state_q <= ST_DONE;
				end
				ST_REL: begin
					if (rel_hit) begin
						in_use_q[rel_addr_s1] <= 1'b0;
					end
					if (sweep_more) begin
						rel_addr_s1 <= cnt_q[IDX_W-1:0];
						cnt_q       <= cnt_q + CNT_W'(1);
					end else begin
						rel_vld_s1   <= 1'b0;
						res_status_q <= 1'b0;
						state_q      <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_status_q <= res_status_q;
						m_grant_q  <= res_grant_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(8 - GRANT_W - 1)'(0), m_grant_q, m_status_q};

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("command taken while another is in progress");

	a_alloc_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_cmd == CMD_ALLOC && any_free) |=> in_use_q[$past(pick_idx)])
		else $error("allocated block not marked in use");

	a_free_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FREE && free_ok) |=> !in_use_q[$past(idx_q)])
		else $error("freed block still marked in use");

	a_sweep_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REL) |-> !tag_req.we)
		else $error("tag write during release sweep");

	a_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && (!m_tvalid_q || m_tready)) |=> m_tvalid_q)
		else $error("result not presented after completion");

endmodule
